>>> sv/esc_pkg.sv
// Shared codes and types for the elevator sweep controller.
// No dependencies; imported by the controller, the datapath and the top level.
package esc_pkg;

    localparam int FLOOR_W = 4;
    localparam int SPEED_W = 7;

    // Event codes carried in func
    localparam logic [2:0] FN_UPDATE  = 3'd0;
    localparam logic [2:0] FN_REQUEST = 3'd1;
    localparam logic [2:0] FN_REACHED = 3'd2;
    localparam logic [2:0] FN_EMERG   = 3'd3;
    localparam logic [2:0] FN_CLEAR   = 3'd4;
    localparam logic [2:0] FN_DOOR    = 3'd5;

    // Controller modes, reported as ctrl_state
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_UP    = 3'd1;
    localparam logic [2:0] MODE_DOWN  = 3'd2;
    localparam logic [2:0] MODE_DOORS = 3'd3;
    localparam logic [2:0] MODE_EMERG = 3'd4;

    // Travel direction codes
    localparam logic [1:0] HEAD_NONE = 2'd0;
    localparam logic [1:0] HEAD_UP   = 2'd1;
    localparam logic [1:0] HEAD_DOWN = 2'd2;

    // Commands from the controller to the datapath, at most one update action per beat
    typedef struct packed {
        logic req;          // set stop bit for the event floor
        logic reach;        // latch a floor-reached event
        logic emerg;        // latch an emergency, drop duty
        logic clear;        // clear emergency and all stops
        logic door;         // latch a door-expired event
        logic enter_emerg;  // update: enter emergency
        logic start_move;   // update: take the scan result as new goal
        logic no_stop;      // update: nothing pending, drop heading
        logic arrive;       // update: consume the reached event
        logic door_close;   // update: consume the door-expired event
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emerg_pending;
        logic found;        // scan found a pending stop
        logic goal_above;   // found stop lies above the current floor
        logic goal_below;   // found stop lies below the current floor
        logic reach_pending;
        logic reach_hit;    // reached floor is requested or is the goal
        logic door_pending;
        logic stops_empty;
    } t_status;

endpackage

>>> sv/elevator_sweep_controller.sv
// Elevator sweep (SCAN) controller.
// Input stream: one event beat per item (func on tuser, floor on tdata). Each accepted
// beat yields exactly one result beat on the output stream showing the state after it.
// Latency: the result beat is valid on the cycle after the input beat is accepted.
// Throughput: one event per cycle while the receiver takes each result; the stop search is a
// combinational priority encoder over the stop vector.
// The state registers double as the output register: while a result beat is held,
// the input side accepts a new beat only in the cycle the result is taken, so a
// stalled receiver stalls the input and no result is lost or overwritten.
// Pulse fields (door timer start/stop, alert) are high only on results of update
// events that caused them.
// Configuration: APB write at byte address 0 (slow_speed) or 4 (full_speed); reads
// return the register. Write only while no event is in flight.
// Reset (synchronous, active low): idle, floor 1, goal 1, no stops, no heading,
// duty 0, no pending events, slow_speed 30, full_speed 100, no result pending.
// Depends on esc_pkg, esc_ctrl and esc_dp.
module elevator_sweep_controller
    import esc_pkg::*;
#(
    parameter int NUM_FLOORS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] floor, [7:4] zero
    input  logic [2:0]  s_tuser,   // [2:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] ctrl_state, [6:3] cur_floor, [10:7] goal_floor,
                                   // [12:11] travel_dir, [19:13] motor_speed,
                                   // [20] door_timer_start, [21] door_timer_stop,
                                   // [22] alert, [23] idle_empty
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SPEED_W-1:0] r_slow_speed;
    logic [SPEED_W-1:0] r_full_speed;

    logic               w_go;
    logic               w_out_taken;
    logic               w_out_valid;
    t_cmd               w_cmd;
    t_status            w_status;
    logic [2:0]         w_mode;
    logic               w_door_start;
    logic               w_door_stop;
    logic               w_alert;
    logic [FLOOR_W-1:0] w_cur_floor;
    logic [FLOOR_W-1:0] w_goal_floor;
    logic [1:0]         w_dir;
    logic [SPEED_W-1:0] w_speed;
    logic               w_idle_empty;

    // Handshake: take a new event when no result waits or it leaves this cycle
    assign w_out_taken = w_out_valid && m_tready;
    assign s_tready    = !w_out_valid || m_tready;
    assign w_go        = s_tvalid && s_tready;

    // Speed registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_speed <= SPEED_W'(30);
            r_full_speed <= SPEED_W'(100);
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_full_speed <= pwdata[SPEED_W-1:0];
            end else begin
                r_slow_speed <= pwdata[SPEED_W-1:0];
            end
        end
    end
    assign prdata = paddr[2] ? 32'(r_full_speed) : 32'(r_slow_speed);

    esc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (w_go),
        .i_out_taken  (w_out_taken),
        .i_func       (s_tuser),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_mode       (w_mode),
        .o_door_start (w_door_start),
        .o_door_stop  (w_door_stop),
        .o_alert      (w_alert),
        .o_out_valid  (w_out_valid)
    );

    esc_dp #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_floor      (s_tdata[3:0]),
        .i_slow_speed (r_slow_speed),
        .i_full_speed (r_full_speed),
        .o_status     (w_status),
        .o_cur_floor  (w_cur_floor),
        .o_goal_floor (w_goal_floor),
        .o_dir        (w_dir),
        .o_speed      (w_speed)
    );

    // Pack the result beat
    assign w_idle_empty = (w_mode == MODE_IDLE) && w_status.stops_empty;
    assign m_tvalid     = w_out_valid;
    assign m_tdata      = {w_idle_empty, w_alert, w_door_stop, w_door_start,
                           w_speed, w_dir, w_goal_floor, w_cur_floor, w_mode};

endmodule

>>> sv/esc_ctrl.sv
// Controller state machine of the elevator sweep controller: mode, pulses, output valid.
// Depends on esc_pkg; drives commands into esc_dp and reads its status.
module esc_ctrl
    import esc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,         // input beat accepted
    input  logic        i_out_taken,  // output beat accepted
    input  logic [2:0]  i_func,
    input  t_status     i_status,
    output t_cmd        o_cmd,
    output logic [2:0]  o_mode,
    output logic        o_door_start,
    output logic        o_door_stop,
    output logic        o_alert,
    output logic        o_out_valid
);

    logic [2:0] r_mode, n_mode;
    logic       r_start, n_start;
    logic       r_stop, n_stop;
    logic       r_alert, n_alert;
    logic       r_out_valid, n_out_valid;

    // Decode the event against the current mode
    always_comb begin
        o_cmd   = '0;
        n_mode  = r_mode;
        n_start = 1'b0;
        n_stop  = 1'b0;
        n_alert = 1'b0;
        unique case (i_func)
            FN_UPDATE: begin
                if (i_status.emerg_pending) begin
                    if (r_mode != MODE_EMERG) begin
                        o_cmd.enter_emerg = 1'b1;
                        n_mode  = MODE_EMERG;
                        n_stop  = 1'b1;
                        n_alert = 1'b1;
                    end
                end else begin
                    unique case (r_mode)
                        MODE_IDLE: begin
                            if (i_status.found) begin
                                o_cmd.start_move = 1'b1;
                                if (i_status.goal_above) begin
                                    n_mode = MODE_UP;
                                end else if (i_status.goal_below) begin
                                    n_mode = MODE_DOWN;
                                end else begin
                                    n_mode  = MODE_DOORS;
                                    n_start = 1'b1;
                                end
                            end else begin
                                o_cmd.no_stop = 1'b1;
                            end
                        end
                        MODE_UP, MODE_DOWN: begin
                            if (i_status.reach_pending) begin
                                o_cmd.arrive = 1'b1;
                                if (i_status.reach_hit) begin
                                    n_mode  = MODE_DOORS;
                                    n_start = 1'b1;
                                end
                            end
                        end
                        MODE_DOORS: begin
                            if (i_status.door_pending) begin
                                o_cmd.door_close = 1'b1;
                                n_mode = MODE_IDLE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FN_REQUEST: o_cmd.req = (r_mode != MODE_EMERG);
            FN_REACHED: o_cmd.reach = 1'b1;
            FN_EMERG:   o_cmd.emerg = 1'b1;
            FN_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_mode = MODE_IDLE;
            end
            FN_DOOR:    o_cmd.door = 1'b1;
            default: begin
            end
        endcase
        // hold everything unless a beat is taken
        if (!i_go) begin
            o_cmd   = '0;
            n_mode  = r_mode;
            n_start = r_start;
            n_stop  = r_stop;
            n_alert = r_alert;
        end
    end

    // Result beat is valid after each accepted event until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_taken) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_start     <= 1'b0;
            r_stop      <= 1'b0;
            r_alert     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_start     <= n_start;
            r_stop      <= n_stop;
            r_alert     <= n_alert;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_mode       = r_mode;
    assign o_door_start = r_start;
    assign o_door_stop  = r_stop;
    assign o_alert      = r_alert;
    assign o_out_valid  = r_out_valid;

endmodule

>>> sv/esc_dp.sv
// Datapath of the elevator sweep controller: stop vector, floors, heading, duty, pending events.
// Depends on esc_pkg; executes commands from esc_ctrl and returns status.
module esc_dp
    import esc_pkg::*;
#(
    parameter int NUM_FLOORS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [FLOOR_W-1:0] i_floor,
    input  logic [SPEED_W-1:0] i_slow_speed,
    input  logic [SPEED_W-1:0] i_full_speed,
    output t_status            o_status,
    output logic [FLOOR_W-1:0] o_cur_floor,
    output logic [FLOOR_W-1:0] o_goal_floor,
    output logic [1:0]         o_dir,
    output logic [SPEED_W-1:0] o_speed
);

    localparam int MAP_W = 1 << FLOOR_W;

    logic [NUM_FLOORS:1]  r_stops, n_stops;
    logic [FLOOR_W-1:0]   r_floor_now, n_floor_now;
    logic [FLOOR_W-1:0]   r_floor_goal, n_floor_goal;
    logic [1:0]           r_heading, n_heading;
    logic [SPEED_W-1:0]   r_duty, n_duty;
    logic                 r_reach_pend, n_reach_pend;
    logic [FLOOR_W-1:0]   r_reach_val, n_reach_val;
    logic                 r_door_pend, n_door_pend;
    logic                 r_emerg_pend, n_emerg_pend;

    logic [MAP_W-1:0]     w_stop_map;
    logic [MAP_W-1:0]     w_in_onehot;
    logic [MAP_W-1:0]     w_now_onehot;
    logic [MAP_W-1:0]     w_reach_onehot;
    logic [FLOOR_W-1:0]   w_scan_up;
    logic [FLOOR_W-1:0]   w_scan_down;
    logic [FLOOR_W-1:0]   w_next;
    logic [1:0]           w_next_dir;
    logic                 w_found;
    logic                 w_above;
    logic                 w_below;
    logic                 w_dist_one;
    logic                 w_reach_hit;

    // Stop bits on a full floor-code map; codes off the valid range read zero
    assign w_stop_map     = MAP_W'({r_stops, 1'b0});
    assign w_in_onehot    = MAP_W'(1) << i_floor;
    assign w_now_onehot   = MAP_W'(1) << r_floor_now;
    assign w_reach_onehot = MAP_W'(1) << r_reach_val;

    // Priority encoders: nearest stop at or above, at or below the current floor
    always_comb begin
        w_scan_up   = '0;
        w_scan_down = '0;
        for (int f = NUM_FLOORS; f >= 1; f--) begin
            if (r_stops[f] && (FLOOR_W'(f) >= r_floor_now)) begin
                w_scan_up = FLOOR_W'(f);
            end
        end
        for (int f = 1; f <= NUM_FLOORS; f++) begin
            if (r_stops[f] && (FLOOR_W'(f) <= r_floor_now)) begin
                w_scan_down = FLOOR_W'(f);
            end
        end
    end

    // Sweep choice: keep the heading, else reverse
    always_comb begin
        if (r_heading == HEAD_UP || r_heading == HEAD_NONE) begin
            if (w_scan_up != '0) begin
                w_next     = w_scan_up;
                w_next_dir = HEAD_UP;
            end else begin
                w_next     = w_scan_down;
                w_next_dir = HEAD_DOWN;
            end
        end else begin
            if (w_scan_down != '0) begin
                w_next     = w_scan_down;
                w_next_dir = HEAD_DOWN;
            end else begin
                w_next     = w_scan_up;
                w_next_dir = HEAD_UP;
            end
        end
    end

    assign w_found     = (w_next != '0);
    assign w_above     = (w_next > r_floor_now);
    assign w_below     = (w_next < r_floor_now);
    assign w_dist_one  = w_above ? ((w_next - r_floor_now) == FLOOR_W'(1))
                                 : ((r_floor_now - w_next) == FLOOR_W'(1));
    assign w_reach_hit = w_stop_map[r_reach_val] || (r_reach_val == r_floor_goal);

    // Execute commands
    always_comb begin
        n_stops      = r_stops;
        n_floor_now  = r_floor_now;
        n_floor_goal = r_floor_goal;
        n_heading    = r_heading;
        n_duty       = r_duty;
        n_reach_pend = r_reach_pend;
        n_reach_val  = r_reach_val;
        n_door_pend  = r_door_pend;
        n_emerg_pend = r_emerg_pend;

        if (i_cmd.req) begin
            n_stops = r_stops | w_in_onehot[NUM_FLOORS:1];
        end
        if (i_cmd.reach) begin
            n_floor_now  = i_floor;
            n_reach_val  = i_floor;
            n_reach_pend = 1'b1;
        end
        if (i_cmd.emerg) begin
            n_duty       = '0;
            n_emerg_pend = 1'b1;
        end
        if (i_cmd.clear) begin
            n_emerg_pend = 1'b0;
            n_stops      = '0;
            n_heading    = HEAD_NONE;
            n_duty       = '0;
            n_floor_goal = r_floor_now;
        end
        if (i_cmd.door) begin
            n_door_pend = 1'b1;
        end
        if (i_cmd.enter_emerg) begin
            n_heading = HEAD_NONE;
            n_duty    = '0;
        end
        if (i_cmd.no_stop) begin
            n_heading = HEAD_NONE;
        end
        if (i_cmd.start_move) begin
            n_floor_goal = w_next;
            n_heading    = w_next_dir;
            if (w_above || w_below) begin
                n_duty = w_dist_one ? i_slow_speed : i_full_speed;
            end else begin
                n_stops = r_stops & ~w_now_onehot[NUM_FLOORS:1];
                n_duty  = '0;
            end
        end
        if (i_cmd.arrive) begin
            n_reach_pend = 1'b0;
            n_floor_now  = r_reach_val;
            if (w_reach_hit) begin
                n_stops = r_stops & ~w_reach_onehot[NUM_FLOORS:1];
                n_duty  = '0;
            end else begin
                n_duty = i_full_speed;
            end
        end
        if (i_cmd.door_close) begin
            n_door_pend = 1'b0;
            n_duty      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stops      <= '0;
            r_floor_now  <= FLOOR_W'(1);
            r_floor_goal <= FLOOR_W'(1);
            r_heading    <= HEAD_NONE;
            r_duty       <= '0;
            r_reach_pend <= 1'b0;
            r_reach_val  <= '0;
            r_door_pend  <= 1'b0;
            r_emerg_pend <= 1'b0;
        end else begin
            r_stops      <= n_stops;
            r_floor_now  <= n_floor_now;
            r_floor_goal <= n_floor_goal;
            r_heading    <= n_heading;
            r_duty       <= n_duty;
            r_reach_pend <= n_reach_pend;
            r_reach_val  <= n_reach_val;
            r_door_pend  <= n_door_pend;
            r_emerg_pend <= n_emerg_pend;
        end
    end

    // Status back to the controller
    always_comb begin
        o_status.emerg_pending = r_emerg_pend;
        o_status.found         = w_found;
        o_status.goal_above    = w_above;
        o_status.goal_below    = w_below;
        o_status.reach_pending = r_reach_pend;
        o_status.reach_hit     = w_reach_hit;
        o_status.door_pending  = r_door_pend;
        o_status.stops_empty   = (r_stops == '0);
    end

    assign o_cur_floor  = r_floor_now;
    assign o_goal_floor = r_floor_goal;
    assign o_dir        = r_heading;
    assign o_speed      = r_duty;

endmodule
